// ===== rtl/stt_pkg.sv =====
package stt_pkg;

  // Table depth and the index widths that follow from it.
  localparam int MAX_TIMERS = 16;
  localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W      = $clog2(MAX_TIMERS + 1);

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_ADD  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_FULL  = 2'd3
  } kind_t;

  typedef struct packed {
    func_t       func;
    logic        from_user;
    logic [31:0] period;
    logic        repeat_req;
  } req_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] timer_id;
    logic [63:0] ms_count;
    logic        last;
  } rsp_word_t;

  // One stored timer.
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] period;
    logic [31:0] count;
    logic        rep;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic  capture;
    logic  tick_start;
    logic  add_store;
    logic  walking;
    logic  step;
    logic  finish;
    logic  emit;
    kind_t emit_kind;
  } stt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic has_entries;
    logic out_free;
    logic fire;
    logic last_entry;
  } stt_sts_t;

endpackage

// ===== rtl/software_timer_table.sv =====
// Software timer table: up to MAX_TIMERS timers kept in insertion order in a
// single-port-read table RAM, plus a 64-bit millisecond counter. An add word
// stores a timer under the next sequential id and answers with that id, or
// answers table full and stores nothing. A tick word bumps the millisecond
// counter; a tick from user mode also walks the table once, counting every
// timer up, reporting each one that reaches its period, restarting repeating
// timers and squeezing one-shot timers out while keeping the order. Every
// tick ends with a done word carrying the counter. A user tick with stored
// timers walks them in order, reading one table entry per cycle through
// the RAM's single read port while no fired word is held up. An added,
// fired, full or done word that is ready waits while the output register
// still holds a word not yet taken. One word is taken at a time; a
// finished word sits in the output register until taken.
module software_timer_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  stt_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output stt_pkg::rsp_word_t rsp
);
  import stt_pkg::*;

  stt_cmd_t cmd;
  stt_sts_t sts;

  // The sequencer decides when to accept, walk and emit.
  stt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_func      (req.func),
    .req_from_user (req.from_user),
    .sts           (sts),
    .req_ready     (req_ready),
    .cmd           (cmd)
  );

  // The datapath owns the counters, the table and the output register.
  stt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/stt_ram.sv =====
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/stt_ctrl.sv =====
module stt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  stt_pkg::func_t   req_func,
  input  logic             req_from_user,
  input  stt_pkg::stt_sts_t sts,
  output logic             req_ready,
  output stt_pkg::stt_cmd_t cmd
);
  import stt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_WALK,
    S_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next    = state;
    req_ready     = 1'b0;
    cmd           = '0;
    cmd.emit_kind = KIND_DONE;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          if (req_func == FUNC_ADD) begin
            state_next = S_ADD;
          end else begin
            cmd.tick_start = 1'b1;
            state_next = (req_from_user && sts.has_entries) ? S_WALK : S_DONE;
          end
        end
      end
      S_ADD: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.full) begin
            cmd.emit_kind = KIND_FULL;
          end else begin
            cmd.add_store = 1'b1;
            cmd.emit_kind = KIND_ADDED;
          end
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.walking = 1'b1;
        // A firing entry waits here until the output register has room.
        if (!(sts.fire && !sts.out_free)) begin
          cmd.step      = 1'b1;
          cmd.emit      = sts.fire;
          cmd.emit_kind = KIND_FIRED;
          if (sts.last_entry) begin
            cmd.finish = 1'b1;
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_DONE;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/stt_dp.sv =====
module stt_dp (
  input  logic               clk,
  input  logic               rst,
  input  stt_pkg::req_word_t req,
  input  logic               rsp_ready,
  input  stt_pkg::stt_cmd_t  cmd,
  output stt_pkg::stt_sts_t  sts,
  output logic               rsp_valid,
  output stt_pkg::rsp_word_t rsp
);
  import stt_pkg::*;

  logic [63:0]      ms_counter;
  logic [31:0]      next_timer_id;
  logic [CNT_W-1:0] active_count;
  logic [CNT_W-1:0] rd;
  logic [CNT_W-1:0] wr;
  logic [31:0]      add_period;
  logic             add_repeat;

  logic [CNT_W-1:0] rd_inc;
  logic [CNT_W-1:0] wr_next;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic             we;
  entry_t           wdata;
  entry_t           cur;
  logic [31:0]      count_inc;
  logic             fire;
  logic             keep;

  stt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_TIMERS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (cur)
  );

  assign rd_inc    = rd + CNT_W'(1);
  assign count_inc = cur.count + 32'd1;
  assign fire      = (cur.period != 32'd0) && (count_inc == cur.period);
  assign keep      = !fire || cur.rep;
  assign wr_next   = wr + CNT_W'(keep);

  // While walking, fetch the next entry as soon as the current one retires.
  assign raddr = cmd.walking ? (cmd.step ? rd_inc[IDX_W-1:0] : rd[IDX_W-1:0]) : '0;

  always_comb begin
    we    = 1'b0;
    waddr = wr[IDX_W-1:0];
    wdata = cur;
    if (cmd.add_store) begin
      we           = 1'b1;
      waddr        = active_count[IDX_W-1:0];
      wdata.id     = next_timer_id;
      wdata.period = add_period;
      wdata.count  = 32'd0;
      wdata.rep    = add_repeat;
    end else if (cmd.step && keep) begin
      we          = 1'b1;
      wdata.count = fire ? 32'd0 : count_inc;
    end
  end

  assign sts.full        = (active_count == CNT_W'(MAX_TIMERS));
  assign sts.has_entries = (active_count != '0);
  assign sts.out_free    = !rsp_valid || rsp_ready;
  assign sts.fire        = fire;
  assign sts.last_entry  = (rd_inc == active_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_counter    <= 64'd0;
      next_timer_id <= 32'd1;
      active_count  <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cmd.tick_start) begin
        ms_counter <= ms_counter + 64'd1;
      end
      if (cmd.add_store) begin
        next_timer_id <= next_timer_id + 32'd1;
        active_count  <= active_count + CNT_W'(1);
      end
      if (cmd.finish) begin
        active_count <= wr_next;
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      add_period <= req.period;
      add_repeat <= req.repeat_req;
    end
    if (cmd.tick_start) begin
      rd <= '0;
      wr <= '0;
    end else if (cmd.step) begin
      rd <= rd_inc;
      wr <= wr_next;
    end
    if (cmd.emit) begin
      rsp.kind     <= cmd.emit_kind;
      rsp.ms_count <= ms_counter;
      rsp.last     <= (cmd.emit_kind != KIND_FIRED);
      unique case (cmd.emit_kind)
        KIND_ADDED: rsp.timer_id <= next_timer_id;
        KIND_FIRED: rsp.timer_id <= cur.id;
        default:    rsp.timer_id <= 32'd0;
      endcase
    end
  end

endmodule

// ===== dv/stt_checker.sv =====
// Watches both channels of the timer table, keeps its own copy of the table
// and the millisecond counter, and compares every returned word with the
// oldest word still owed.
module stt_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  stt_pkg::req_word_t req,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  stt_pkg::rsp_word_t rsp,
  output int                 errors,
  output int                 pending
);
  import stt_pkg::*;

  logic [63:0]  ms_now;
  logic [31:0]  id_next;
  int unsigned  n_live;
  entry_t       slots [MAX_TIMERS];
  rsp_word_t    replies_due [$];
  int           err_cnt;

  function automatic rsp_word_t reply(kind_t k, logic [31:0] id, logic fin);
    rsp_word_t r;
    r          = '0;
    r.kind     = k;
    r.timer_id = id;
    r.ms_count = ms_now;
    r.last     = fin;
    return r;
  endfunction

  // Appends a word to the end of the list still owed.
  task automatic owe(input rsp_word_t r);
    replies_due = {replies_due, r};
  endtask

  // Applies one accepted word to the shadow table and queues what it owes.
  task automatic table_step(input req_word_t w);
    int unsigned i;
    int unsigned j;
    if (w.func == FUNC_ADD) begin
      if (n_live >= MAX_TIMERS) begin
        owe(reply(KIND_FULL, 32'd0, 1'b1));
      end else begin
        slots[n_live].id     = id_next;
        slots[n_live].period = w.period;
        slots[n_live].count  = 32'd0;
        slots[n_live].rep    = w.repeat_req;
        n_live++;
        owe(reply(KIND_ADDED, id_next, 1'b1));
        id_next = id_next + 32'd1;
      end
    end else begin
      ms_now = ms_now + 64'd1;
      if (w.from_user) begin
        i = 0;
        while (i < n_live) begin
          slots[i].count = slots[i].count + 32'd1;
          if (slots[i].period != 32'd0 && slots[i].count == slots[i].period) begin
            owe(reply(KIND_FIRED, slots[i].id, 1'b0));
            if (slots[i].rep) begin
              slots[i].count = 32'd0;
              i++;
            end else begin
              // One-shot timers leave; later entries move up in order.
              for (j = i; j + 1 < n_live; j++) slots[j] = slots[j + 1];
              n_live--;
            end
          end else begin
            i++;
          end
        end
      end
      owe(reply(KIND_DONE, 32'd0, 1'b1));
    end
  endtask

  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      ms_now  = 64'd0;
      id_next = 32'd1;
      n_live  = 0;
      replies_due.delete();
    end else begin
      if (req_valid && req_ready) table_step(req);
      if (rsp_valid && rsp_ready) begin
        if (replies_due.size() == 0) begin
          err_cnt++;
          $error("unexpected word: kind %0d timer_id %0d ms_count %0d last %0d",
                 rsp.kind, rsp.timer_id, rsp.ms_count, rsp.last);
        end else begin
          want = replies_due.pop_front();
          if (rsp.kind !== want.kind) begin
            err_cnt++;
            $error("kind: expected %0d, got %0d", want.kind, rsp.kind);
          end
          if (rsp.timer_id !== want.timer_id) begin
            err_cnt++;
            $error("timer_id: expected %0d, got %0d", want.timer_id, rsp.timer_id);
          end
          if (rsp.ms_count !== want.ms_count) begin
            err_cnt++;
            $error("ms_count: expected %0d, got %0d", want.ms_count, rsp.ms_count);
          end
          if (rsp.last !== want.last) begin
            err_cnt++;
            $error("last: expected %0d, got %0d", want.last, rsp.last);
          end
        end
      end
    end
    errors  <= err_cnt;
    pending <= replies_due.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the timer table bench. It makes the clock and reset, drives request
// words, plays the part of a slow consumer on the reply channel and gives the
// verdict. All prediction and checking lives in the checker next to the block.
module testbench;
  import stt_pkg::*;

  localparam int RANDOM_WORDS = 208;
  // Worst case is roughly 17 replies per word, each waiting out a random
  // stall, plus the long hold-off; this limit is several times that.
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_word_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_word_t rsp;

  int fail_count;
  int words_owed;

  // Shared between the sender and the consumer: while steady is set neither
  // side inserts gaps, and sent_count lets the consumer time its hold-off.
  bit steady;
  int sent_count;

  software_timer_table uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  stt_checker chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .errors    (fail_count),
    .pending   (words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A tick word. The add-only fields carry random junk, since the block has
  // to ignore them on a tick.
  function automatic req_word_t tick_word(logic user);
    req_word_t w;
    w.func       = FUNC_TICK;
    w.from_user  = user;
    w.period     = $urandom;
    w.repeat_req = 1'($urandom_range(1));
    return w;
  endfunction

  // An add word; from_user is junk here for the same reason.
  function automatic req_word_t add_word(logic [31:0] ticks, logic rep);
    req_word_t w;
    w.func       = FUNC_ADD;
    w.from_user  = 1'($urandom_range(1));
    w.period     = ticks;
    w.repeat_req = rep;
    return w;
  endfunction

  // Offers one word and returns once it has been taken. Random gaps come
  // first unless a steady stretch is running. Inputs change only on the
  // rising edge, and outputs read right after the edge still show their
  // values from before it, so the handshake test is free of races.
  task automatic send_word(input req_word_t w);
    while (!steady && $urandom_range(99) < 32) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sent_count++;
  endtask

  // Reply consumer. It stalls about a third of the time, never during the
  // steady stretch, and once holds off for a long run of cycles while the
  // sender keeps going, so the block backs up and has to refuse new words.
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent_count >= 170) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(99) >= 32);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned k;
    int unsigned pick;
    logic [31:0] ticks;
    rst        <= 1'b1;
    req_valid  <= 1'b0;
    req        <= '0;
    steady     = 1'b0;
    sent_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Ticks on an empty table, from kernel and from user mode.
    send_word(tick_word(1'b0));
    send_word(tick_word(1'b1));
    // A timer that never fires, one with the largest period, a one-shot and
    // repeating timers with the shortest periods.
    send_word(add_word(32'd0, 1'b0));
    send_word(add_word(32'hFFFF_FFFF, 1'b1));
    send_word(add_word(32'd1, 1'b0));
    send_word(add_word(32'd2, 1'b1));
    send_word(add_word(32'd1, 1'b1));
    // The first user tick removes the one-shot from the middle of the table;
    // the second fires two repeating timers in order.
    send_word(tick_word(1'b1));
    send_word(tick_word(1'b1));
    // A kernel tick moves only the millisecond counter.
    send_word(tick_word(1'b0));
    // Fill the table with one-shots that all expire together, then try one
    // more add, which must come back as table full.
    for (k = 0; k < 12; k++) send_word(add_word(32'd3, 1'b0));
    send_word(add_word(32'd7, 1'b1));
    // The third of these ticks fires a burst and empties most of the table.
    repeat (3) send_word(tick_word(1'b1));

    // Random traffic. Adds mostly use short periods so timers keep firing and
    // leaving; zero, full-range periods and repeating timers are kept rare
    // because they stay in the table for good.
    for (k = 0; k < RANDOM_WORDS; k++) begin
      steady = (k >= 60 && k < 110);
      if (k == 200) begin
        // Let the block drain completely before going on.
        req_valid <= 1'b0;
        do @(posedge clk); while (words_owed != 0);
      end
      if ($urandom_range(99) < 38) begin
        pick = $urandom_range(99);
        if (pick < 3) ticks = 32'd0;
        else if (pick < 6) ticks = $urandom;
        else ticks = $urandom_range(12, 1);
        send_word(add_word(ticks, ($urandom_range(99) < 10)));
      end else begin
        send_word(tick_word($urandom_range(99) < 85));
      end
    end
    steady = 1'b0;

    req_valid <= 1'b0;
    do @(posedge clk); while (words_owed != 0);
    // A user tick with a full table walks at most MAX_TIMERS entries, so
    // anything stray would show up well within this window.
    repeat (40) @(posedge clk);

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== software_timer_table.f =====
rtl/stt_pkg.sv
rtl/stt_ram.sv
rtl/stt_ctrl.sv
rtl/stt_dp.sv
rtl/software_timer_table.sv
dv/stt_checker.sv
dv/testbench.sv
